@@ sv/evs_pkg.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// evs_pkg
// Shared constants, register indexes and control structs of the encoder
// velocity smoother.
//------------------------------------------------------------------------------
package evs_pkg;

    // default history depth
    localparam int EVS_HIST_DEPTH = 8;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_OFFSET     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_FACTOR = 2'd2;

    // register reset values
    localparam logic [15:0] RST_COUNT_OFFSET     = 16'h0000;
    localparam logic [31:0] RST_VELOCITY_SCALE   = 32'h0001_0000;
    localparam logic [15:0] RST_SMOOTHING_FACTOR = 16'h8000;

    // fixed-point constants
    localparam logic [15:0] WGT_UNITY = 16'hFFFF;
    localparam logic [16:0] Q16_ONE   = 17'h1_0000;

    localparam logic signed [31:0] VEL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] VEL_MIN = 32'sh8000_0000;

    // divider widths: |count - offset| * scale over elapsed ticks
    localparam int NUM_W = 48;
    localparam int DEN_W = 16;

    // top level to filter engine
    typedef struct packed {
        logic        start;
        logic        raw_ok;
        logic [31:0] raw;
    } t_filt_ctl;

    // filter engine to top level
    typedef struct packed {
        logic        done;
        logic [31:0] filt;
    } t_filt_sts;

endpackage

@@ sv/evs_div.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// evs_div
// Restoring unsigned divider, one quotient bit per cycle.
//------------------------------------------------------------------------------
module evs_div
    import evs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             fits;

    // trial subtraction of the shifted partial remainder
    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        fits    = (rem_sh >= {1'b0, r_den});
    end

    // step counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out as the quotient shifts in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ sv/evs_wgt.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// evs_wgt
// Tap weight memory: powers of the smoothing factor, rebuilt one entry per
// cycle after reset and after each factor write.
//------------------------------------------------------------------------------
module evs_wgt
    import evs_pkg::*;
#(
    parameter int HISTORY_DEPTH = EVS_HIST_DEPTH,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rebuild,
    input  logic [15:0]   i_factor,
    input  logic [AW-1:0] i_rd_addr,
    output logic [15:0]   o_rd_data,
    output logic          o_busy
);

    logic [15:0]   r_mem [HISTORY_DEPTH];
    logic [15:0]   r_rd_data;
    logic          r_busy;
    logic [AW-1:0] r_j;
    logic [15:0]   r_prev;

    logic [31:0]   prod;
    logic [15:0]   n_w;

    // next weight: unity, the factor, then truncated products
    always_comb begin
        prod = r_prev * i_factor;
        priority if (r_j == AW'(0)) begin
            n_w = WGT_UNITY;
        end else if (r_j == AW'(1)) begin
            n_w = i_factor;
        end else begin
            n_w = prod[31:16];
        end
    end

    // rebuild sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_j    <= '0;
        end else if (i_rebuild) begin
            r_busy <= 1'b1;
            r_j    <= '0;
        end else if (r_busy) begin
            if (r_j == AW'(HISTORY_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_j] <= n_w;
            r_prev     <= n_w;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

@@ sv/evs_filt.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// evs_filt
// History memory and filter engine: walks the history slots through a
// multiply-accumulate pipeline, combines with the raw velocity and writes
// the new output back as the newest slot.
//------------------------------------------------------------------------------
module evs_filt
    import evs_pkg::*;
#(
    parameter int HISTORY_DEPTH = EVS_HIST_DEPTH,
    localparam int AW = $clog2(HISTORY_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_filt_ctl     i_ctl,
    input  logic [15:0]   i_factor,
    output logic [AW-1:0] o_wgt_addr,
    input  logic [15:0]   i_wgt_data,
    output t_filt_sts     o_sts
);

    // slots 1 .. HISTORY_DEPTH-1 live in a circular buffer
    localparam int SLOTS = HISTORY_DEPTH - 1;
    localparam int HAW   = $clog2(SLOTS);
    localparam int ACC_W = 48 + AW;
    localparam int S_W   = ACC_W - 15;
    localparam int Y1_W  = S_W + 18;
    localparam int Y_W   = Y1_W + 1;
    localparam int YS_W  = Y_W - 16;
    localparam int HI_W  = YS_W - 31;

    localparam logic [2:0] FS_IDLE = 3'd0;
    localparam logic [2:0] FS_WALK = 3'd1;
    localparam logic [2:0] FS_WAIT = 3'd2;
    localparam logic [2:0] FS_MUL  = 3'd3;
    localparam logic [2:0] FS_ADD  = 3'd4;
    localparam logic [2:0] FS_WR   = 3'd5;

    logic [31:0]             r_hist [SLOTS];
    logic [31:0]             r_hist_rd;

    logic [2:0]              r_state;
    logic [HAW-1:0]          r_head;
    logic [AW-1:0]           r_fill;
    logic [2:0]              r_nz;
    logic [HAW-1:0]          r_rp;
    logic [AW-1:0]           r_j;
    logic                    r_issue;
    logic                    r_v1;
    logic                    r_v1_slot;
    logic                    r_v1_last;
    logic                    r_v2;
    logic                    r_v2_last;
    logic signed [47:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [47:0]      r_tail;
    logic signed [S_W-1:0]   r_s;
    logic                    r_use;
    logic signed [Y1_W-1:0]  r_y1;
    logic [31:0]             r_filt;

    logic [HAW-1:0]          rp_dec;
    logic [HAW-1:0]          head_inc;
    logic signed [48:0]      prod_full;
    logic [ACC_W-17:0]       acc_sh;
    logic signed [S_W-1:0]   s_sum;
    logic [16:0]             one_minus;
    logic signed [Y_W-1:0]   y_sum;
    logic [YS_W-1:0]         y_sh;
    logic [HI_W-1:0]         y_hi;
    logic [31:0]             y_sat;
    logic [31:0]             n_filt;

    // pointer wrap, tap product and output combine
    always_comb begin
        rp_dec    = (r_rp == '0) ? HAW'(SLOTS - 1) : r_rp - 1'b1;
        head_inc  = (r_head == HAW'(SLOTS - 1)) ? '0 : r_head + 1'b1;
        prod_full = $signed(r_hist_rd) * $signed({1'b0, i_wgt_data});
        acc_sh    = r_acc[ACC_W-1:16];
        s_sum     = $signed({acc_sh[ACC_W-17], acc_sh})
                  + $signed({{(S_W-32){i_ctl.raw[31]}}, i_ctl.raw});
        one_minus = Q16_ONE - {1'b0, i_factor};
        y_sum     = $signed({r_y1[Y1_W-1], r_y1})
                  + $signed({{(Y_W-48){r_tail[47]}}, r_tail});
        y_sh      = y_sum[Y_W-1:16];
        y_hi      = y_sh[YS_W-1:31];
        if ((y_hi == '0) || (y_hi == '1)) begin
            y_sat = y_sh[31:0];
        end else if (y_sh[YS_W-1]) begin
            y_sat = VEL_MIN;
        end else begin
            y_sat = VEL_MAX;
        end
        n_filt = r_use ? y_sat : i_ctl.raw;
    end

    // sequencer and history bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_head  <= '0;
            r_fill  <= '0;
            r_nz    <= '0;
            r_issue <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_v1 <= r_issue;
            r_v2 <= r_v1;
            if (r_issue) begin
                if (r_j == AW'(SLOTS)) begin
                    r_issue <= 1'b0;
                end
            end
            unique case (r_state)
                FS_IDLE: begin
                    if (i_ctl.start) begin
                        r_issue <= 1'b1;
                        r_state <= FS_WALK;
                    end
                end
                FS_WALK: begin
                    if (r_v2 && r_v2_last) begin
                        r_state <= FS_WAIT;
                    end
                end
                FS_WAIT: begin
                    if (i_ctl.raw_ok) begin
                        r_state <= FS_MUL;
                    end
                end
                FS_MUL: begin
                    r_state <= FS_ADD;
                end
                FS_ADD: begin
                    r_state <= FS_WR;
                end
                FS_WR: begin
                    r_head  <= head_inc;
                    r_fill  <= (r_fill == AW'(SLOTS)) ? r_fill : r_fill + 1'b1;
                    r_nz    <= {r_nz[1:0], (r_filt != '0)};
                    r_state <= FS_IDLE;
                end
                default: begin
                    r_state <= FS_IDLE;
                end
            endcase
        end
    end

    // walk pipeline: issue, memory read, product, accumulate
    always_ff @(posedge i_clk) begin
        if ((r_state == FS_IDLE) && i_ctl.start) begin
            r_rp  <= r_head;
            r_j   <= AW'(1);
            r_acc <= '0;
        end else begin
            if (r_issue) begin
                r_rp <= rp_dec;
                r_j  <= r_j + 1'b1;
            end
            if (r_v2) begin
                if (r_v2_last) begin
                    r_tail <= r_prod;
                end else begin
                    r_acc <= r_acc + $signed({{(ACC_W-48){r_prod[47]}}, r_prod});
                end
            end
        end
        r_v1_slot <= (r_j <= r_fill);
        r_v1_last <= (r_j == AW'(SLOTS));
        r_v2_last <= r_v1_last;
        r_prod    <= r_v1_slot ? prod_full[47:0] : '0;
    end

    // combine stages
    always_ff @(posedge i_clk) begin
        if ((r_state == FS_WAIT) && i_ctl.raw_ok) begin
            r_s   <= s_sum;
            r_use <= &r_nz;
        end
        if (r_state == FS_MUL) begin
            r_y1 <= r_s * $signed({1'b0, one_minus});
        end
        if (r_state == FS_ADD) begin
            r_filt <= n_filt;
        end
    end

    // history memory, written after the walk has read every slot
    always_ff @(posedge i_clk) begin
        if (r_state == FS_WR) begin
            r_hist[head_inc] <= r_filt;
        end
        r_hist_rd <= r_hist[r_rp];
    end

    assign o_wgt_addr = r_j;
    assign o_sts.done = (r_state == FS_WR);
    assign o_sts.filt = r_filt;

endmodule

@@ sv/encoder_velocity_smoother.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// encoder_velocity_smoother
// Each sample's result waits on the 48-step serial divider that forms the
// raw velocity; the walk over the history memory (one slot per cycle) runs
// beside the divider and takes longer than it for histories deeper than 49
// slots. One sample is in work at a time; the next one is taken while the
// previous result still sits in the output register.
// After reset and after every smoothing factor write the tap weights are
// rebuilt, and no sample is taken during the rebuild.
//------------------------------------------------------------------------------
module encoder_velocity_smoother
    import evs_pkg::*;
#(
    parameter int HISTORY_DEPTH = EVS_HIST_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [15:0]           i_elapsed_ticks,
    input  logic [15:0]           i_encoder_count,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic signed [31:0]    o_filtered_velocity,
    output logic signed [31:0]    o_raw_velocity,
    output logic                  o_divide_error
);

    localparam int AW = $clog2(HISTORY_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    logic [15:0]      r_count_offset;
    logic [31:0]      r_velocity_scale;
    logic [15:0]      r_smoothing_factor;

    logic [1:0]       r_state;
    logic             r_neg;
    logic             r_dzero;
    logic             r_err;
    logic [15:0]      r_mag;
    logic [15:0]      r_den;
    logic [NUM_W-1:0] r_num;
    logic             r_div_go;
    logic             r_start;
    logic             r_raw_ok;
    logic [31:0]      r_raw;
    logic [31:0]      r_pend_filt;
    logic             r_out_valid;
    logic [31:0]      r_out_filt;
    logic [31:0]      r_out_raw;
    logic             r_out_err;

    logic [16:0]      d_diff;
    logic [15:0]      mag;
    logic [NUM_W-1:0] n_num;
    logic [31:0]      n_raw;
    logic             in_accept;
    logic             out_free;
    logic             wgt_busy;
    logic             rebuild;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    logic [AW-1:0]    wgt_addr;
    logic [15:0]      wgt_data;
    t_filt_ctl        filt_ctl;
    t_filt_sts        filt_sts;

    // handshakes
    assign o_in_ready = (r_state == ST_IDLE) && !wgt_busy;
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign rebuild    = i_cfg_we && (i_cfg_idx == CFG_SMOOTHING_FACTOR);

    // signed count difference, its magnitude and the scaled dividend
    always_comb begin
        d_diff = {1'b0, i_encoder_count} - {1'b0, r_count_offset};
        mag    = d_diff[16] ? (~d_diff[15:0] + 16'd1) : d_diff[15:0];
        n_num  = r_mag * r_velocity_scale;
    end

    // raw velocity from the quotient, with sign and saturation
    always_comb begin
        priority if (r_err) begin
            n_raw = r_neg ? VEL_MIN : (r_dzero ? 32'd0 : VEL_MAX);
        end else if (r_neg) begin
            n_raw = (div_quo > 48'h0000_8000_0000) ? VEL_MIN : (~div_quo[31:0] + 32'd1);
        end else begin
            n_raw = (div_quo > 48'h0000_7FFF_FFFF) ? VEL_MAX : div_quo[31:0];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_offset     <= RST_COUNT_OFFSET;
            r_velocity_scale   <= RST_VELOCITY_SCALE;
            r_smoothing_factor <= RST_SMOOTHING_FACTOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COUNT_OFFSET:     r_count_offset     <= i_cfg_data[15:0];
                CFG_VELOCITY_SCALE:   r_velocity_scale   <= i_cfg_data[31:0];
                CFG_SMOOTHING_FACTOR: r_smoothing_factor <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // sample sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_go    <= 1'b0;
            r_start     <= 1'b0;
            r_raw_ok    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_div_go <= 1'b0;
            r_start  <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_start  <= 1'b1;
                        r_raw_ok <= 1'b0;
                        r_state  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_div_go <= 1'b1;
                    r_state  <= ST_RUN;
                end
                ST_RUN: begin
                    if (div_done) begin
                        r_raw_ok <= 1'b1;
                    end
                    if (filt_sts.done) begin
                        if (out_free) begin
                            r_out_valid <= 1'b1;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // sample and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_neg   <= d_diff[16];
            r_dzero <= (d_diff == '0);
            r_err   <= (i_elapsed_ticks == '0);
            r_mag   <= mag;
            r_den   <= i_elapsed_ticks;
        end
        if (r_state == ST_MUL) begin
            r_num <= n_num;
        end
        if (div_done) begin
            r_raw <= n_raw;
        end
        if ((r_state == ST_RUN) && filt_sts.done) begin
            r_pend_filt <= filt_sts.filt;
        end
        if ((r_state == ST_RUN) && filt_sts.done && out_free) begin
            r_out_filt <= filt_sts.filt;
            r_out_raw  <= r_raw;
            r_out_err  <= r_err;
        end else if ((r_state == ST_HOLD) && out_free) begin
            r_out_filt <= r_pend_filt;
            r_out_raw  <= r_raw;
            r_out_err  <= r_err;
        end
    end

    assign filt_ctl.start  = r_start;
    assign filt_ctl.raw_ok = r_raw_ok;
    assign filt_ctl.raw    = r_raw;

    // raw velocity divider
    evs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // tap weight memory
    evs_wgt #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_wgt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rebuild (rebuild),
        .i_factor  (r_smoothing_factor),
        .i_rd_addr (wgt_addr),
        .o_rd_data (wgt_data),
        .o_busy    (wgt_busy)
    );

    // history memory and filter engine
    evs_filt #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_filt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (filt_ctl),
        .i_factor   (r_smoothing_factor),
        .o_wgt_addr (wgt_addr),
        .i_wgt_data (wgt_data),
        .o_sts      (filt_sts)
    );

    assign o_out_valid         = r_out_valid;
    assign o_filtered_velocity = r_out_filt;
    assign o_raw_velocity      = r_out_raw;
    assign o_divide_error      = r_out_err;

endmodule

@@ sv/evs_chk.sv @@
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// evs_chk
// Port-level checks of the encoder velocity smoother, bound to the top level.
//------------------------------------------------------------------------------
module evs_chk
    import evs_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic signed [31:0]    o_filtered_velocity,
    input logic signed [31:0]    o_raw_velocity,
    input logic                  o_divide_error
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_filtered_velocity)
            && $stable(o_raw_velocity) && $stable(o_divide_error))
        else $error("result changed while stalled");

    // zero elapsed ticks gives a saturated or zero raw velocity
    a_err_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_divide_error |->
            o_raw_velocity == VEL_MAX || o_raw_velocity == VEL_MIN
            || o_raw_velocity == 32'sd0)
        else $error("divide error with unsaturated raw velocity");

    // one sample in work at a time
    a_one_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a sample is in work");

    // a smoothing factor write blocks input during the weight rebuild
    a_rebuild_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && i_cfg_idx == CFG_SMOOTHING_FACTOR |=> !o_in_ready)
        else $error("input ready during weight rebuild");

    // reset starts a weight rebuild
    a_reset_block: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

endmodule

bind encoder_velocity_smoother evs_chk u_evs_chk (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_cfg_we            (i_cfg_we),
    .i_cfg_idx           (i_cfg_idx),
    .i_in_valid          (i_in_valid),
    .o_in_ready          (o_in_ready),
    .o_out_valid         (o_out_valid),
    .i_out_ready         (i_out_ready),
    .o_filtered_velocity (o_filtered_velocity),
    .o_raw_velocity      (o_raw_velocity),
    .o_divide_error      (o_divide_error)
);
